// ----- rtl/core/bbc_pkg.sv -----
// Shared types and constants of the bracket balance checker.
package bbc_pkg;

  localparam logic [7:0] CH_ROUND_OPEN   = 8'h28;  // (
  localparam logic [7:0] CH_ROUND_CLOSE  = 8'h29;  // )
  localparam logic [7:0] CH_CURLY_OPEN   = 8'h7B;  // {
  localparam logic [7:0] CH_CURLY_CLOSE  = 8'h7D;  // }
  localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B;  // [
  localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;  // ]

  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_CURLY  = 2'd1,
    KIND_SQUARE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_PLAIN = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CODE_OK       = 3'd0,
    CODE_MISMATCH = 3'd1,
    CODE_EMPTY    = 3'd2,
    CODE_UNCLOSED = 3'd3,
    CODE_OVERFLOW = 3'd4
  } code_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic       balanced;
    logic [2:0] verdict_code;
  } result_t;

  // Classified request passed from front to back.
  typedef struct packed {
    op_t   op;
    kind_t kind;
    logic  last;
  } cls_item_t;

endpackage

// ----- rtl/core/bbc_fifo.sv -----
// Small synchronous FIFO on flip-flops.
module bbc_fifo #(
  parameter int AW    = 1,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int DEPTH = 1 << AW;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW:0]      wr_ptr;
  logic [AW:0]      rd_ptr;

  assign empty   = (wr_ptr == rd_ptr);
  assign full    = (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]) && (wr_ptr[AW] != rd_ptr[AW]);
  assign rd_data = slots[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      slots[wr_ptr[AW-1:0]] <= wr_data;
    end
  end

endmodule

// ----- rtl/core/bbc_front.sv -----
// Front end: mode register and byte classification.
module bbc_front
  import bbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data,
  input  in_item_t  item,
  output cls_item_t cls
);

  logic round_only;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      round_only <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      round_only <= cfg_data;
    end
  end

  always_comb begin
    cls.op   = OP_PLAIN;
    cls.kind = KIND_NONE;
    cls.last = item.is_last;
    if (item.char_byte == CH_ROUND_OPEN) begin
      cls.op   = OP_OPEN;
      cls.kind = KIND_ROUND;
    end else if (item.char_byte == CH_ROUND_CLOSE) begin
      cls.op   = OP_CLOSE;
      cls.kind = KIND_ROUND;
    end else if (!round_only) begin
      if (item.char_byte == CH_CURLY_OPEN) begin
        cls.op   = OP_OPEN;
        cls.kind = KIND_CURLY;
      end else if (item.char_byte == CH_SQUARE_OPEN) begin
        cls.op   = OP_OPEN;
        cls.kind = KIND_SQUARE;
      end else if (item.char_byte == CH_CURLY_CLOSE) begin
        cls.op   = OP_CLOSE;
        cls.kind = KIND_CURLY;
      end else if (item.char_byte == CH_SQUARE_CLOSE) begin
        cls.op   = OP_CLOSE;
        cls.kind = KIND_SQUARE;
      end
    end
  end

endmodule

// ----- rtl/core/bbc_back.sv -----
// Back end: bracket stack with registered top, error latch and verdict.
module bbc_back
  import bbc_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  cls_item_t cur,
  output logic      in_take,
  input  logic      out_full,
  output logic      out_wr,
  output result_t   out_data
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // top_kind holds entry depth-1; mem holds entries below it.
  logic [1:0]    mem [STACK_DEPTH];
  kind_t         top_kind;
  kind_t         below_kind;   // entry depth-2, read ahead
  logic [DW-1:0] depth;
  code_t         err;

  logic [DW-1:0] depth_next;
  code_t         err_next;
  kind_t         top_next;
  logic          do_push;
  logic          do_pop;
  logic          mem_wr;
  logic [DW-1:0] rd_idx;
  code_t         verdict;
  logic          step;

  assign step    = in_valid && !out_full;
  assign in_take = step;

  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    err_next = err;
    if (err == CODE_OK) begin
      case (cur.op)
        OP_OPEN: begin
          if (depth >= DW'(STACK_DEPTH)) err_next = CODE_OVERFLOW;
          else                           do_push  = 1'b1;
        end
        OP_CLOSE: begin
          if (depth == '0)             err_next = CODE_EMPTY;
          else if (top_kind != cur.kind) err_next = CODE_MISMATCH;
          else                         do_pop   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    depth_next = depth;
    top_next   = top_kind;
    if (do_push) begin
      depth_next = depth + 1'b1;
      top_next   = cur.kind;
    end else if (do_pop) begin
      depth_next = depth - 1'b1;
      top_next   = below_kind;
    end
  end

  assign mem_wr = step && do_push && (depth != '0);
  assign rd_idx = depth_next - DW'(2);

  always_comb begin
    if (err_next != CODE_OK) verdict = err_next;
    else if (depth_next != '0) verdict = CODE_UNCLOSED;
    else verdict = CODE_OK;
  end

  assign out_wr                = step && cur.last;
  assign out_data.balanced     = (verdict == CODE_OK);
  assign out_data.verdict_code = verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      err   <= CODE_OK;
    end else if (step) begin
      if (cur.last) begin
        depth <= '0;
        err   <= CODE_OK;
      end else begin
        depth <= depth_next;
        err   <= err_next;
      end
    end
  end

  // Read-ahead of the entry under the new top; forward a same-cycle write.
  always_ff @(posedge clk) begin
    if (step) begin
      top_kind <= top_next;
      if (mem_wr) begin
        mem[AW'(depth - 1'b1)] <= top_kind;
      end
      if (mem_wr && (rd_idx[AW-1:0] == AW'(depth - 1'b1))) begin
        below_kind <= top_kind;
      end else begin
        below_kind <= kind_t'(mem[rd_idx[AW-1:0]]);
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && cur.last |=> depth == '0 && err == CODE_OK)
    else $error("string state not cleared after last byte");

  a_hold_on_error: assert property (@(posedge clk) disable iff (rst)
    step && err != CODE_OK && !cur.last |=> $stable(depth) && $stable(err))
    else $error("state changed after error latched");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    step && do_push && !cur.last |=> depth == $past(depth) + 1'b1 && top_kind == $past(cur.kind))
    else $error("push did not update stack top");

  a_verdict_on_last: assert property (@(posedge clk) disable iff (rst)
    out_wr |-> in_valid && cur.last && !out_full)
    else $error("verdict without last byte");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    step |=> depth <= DW'(STACK_DEPTH))
    else $error("stack depth out of range");

endmodule

// ----- rtl/core/bracket_balance_checker.sv -----
// Top level of the bracket balance checker.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------
//   input    | push / full            | item   (char_byte, is_last)
//   result   | pop / empty            | result (balanced, verdict_code)
//   config   | cfg_valid / cfg_ready  | cfg_data (round_only)
//
// One byte per cycle sustained while the result queue has room; a byte reaches the stack
// after it is registered in the request queue. The stack keeps its top in a register with
// the next entry read ahead, so push or pop needs no wait on a memory read. Bytes wait in a
// request queue of 2**QUEUE_AW entries; verdicts in a result queue of the same depth. A full
// result queue stalls the stack side; push then stalls once the request queue fills behind it.
// Reset clears pointers, stack depth, error latch and mode; stack contents stay undefined.
module bracket_balance_checker
  import bbc_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int QUEUE_AW    = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  output logic     empty,
  input  logic     pop,
  output result_t  result,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  cls_item_t cls_in;
  cls_item_t cls_out;
  logic      mid_empty;
  logic      mid_take;
  logic      res_full;
  logic      res_wr;
  result_t   res_data;

  bbc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .item      (item),
    .cls       (cls_in)
  );

  bbc_fifo #(
    .AW    (QUEUE_AW),
    .WIDTH ($bits(cls_item_t))
  ) u_req_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (cls_in),
    .full    (full),
    .rd_en   (mid_take),
    .rd_data (cls_out),
    .empty   (mid_empty)
  );

  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!mid_empty),
    .cur      (cls_out),
    .in_take  (mid_take),
    .out_full (res_full),
    .out_wr   (res_wr),
    .out_data (res_data)
  );

  bbc_fifo #(
    .AW    (QUEUE_AW),
    .WIDTH ($bits(result_t))
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_wr),
    .wr_data (res_data),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule
